FILE: rtl/rhtt_pkg.sv
`default_nettype none

package rhtt_pkg;

    // Number of region slots in the chain.
    localparam int SLOTS = 16;

    // Width of a cell position, and the width used to compare it against a slot number.
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;

    // Field widths of the stream payloads.
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 24;
    localparam int RES_W      = 22;

    // Operation codes.
    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_EDIT   = 3'd2,
        OP_CLICK  = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    // Inclusive rectangle bounds, x_left in the lowest bits.
    typedef struct packed {
        logic signed [15:0] y_bottom;
        logic signed [15:0] x_right;
        logic signed [15:0] y_top;
        logic signed [15:0] x_left;
    } rect_t;

    // Request as it travels down the chain, with the answers gathered so far.
    typedef struct packed {
        op_t                func;
        logic [3:0]         slot;
        rect_t              rect;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               claimed;
        logic [3:0]         idx;
        logic               got;
    } cmd_t;

    // Result, slot_index in the lowest bits.
    typedef struct packed {
        logic [15:0] hit_mask;
        logic        slot_clicked;
        logic        table_full;
        logic [3:0]  slot_index;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/rhtt_cell.sv
`default_nettype none

module rhtt_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [rhtt_pkg::IDX_W-1:0]   cell_id,
    input  wire logic                         tok_in_valid,
    input  wire rhtt_pkg::cmd_t               tok_in,
    output logic                              tok_out_valid,
    output rhtt_pkg::cmd_t                    tok_out,
    output logic                              flag
);

    logic             valid_reg;
    logic             valid_next;
    logic             flag_reg;
    logic             flag_next;
    rhtt_pkg::rect_t  rect_reg;
    rhtt_pkg::rect_t  rect_next;
    logic             tok_valid_reg;
    rhtt_pkg::cmd_t   tok_reg;
    rhtt_pkg::cmd_t   tok_next;
    logic             slot_match;
    logic             hit;

    // This cell is the one named by the request's slot field.
    assign slot_match = (rhtt_pkg::CMP_W'(tok_in.slot) == rhtt_pkg::CMP_W'(cell_id));

    // Inclusive point-in-rectangle test against the stored bounds.
    assign hit = (tok_in.point_x >= rect_reg.x_left) && (tok_in.point_x <= rect_reg.x_right) &&
                 (tok_in.point_y >= rect_reg.y_top) && (tok_in.point_y <= rect_reg.y_bottom);

    // Act on the passing request and update what travels on.
    always_comb
    begin
        valid_next = valid_reg;
        flag_next  = flag_reg;
        rect_next  = rect_reg;
        tok_next   = tok_in;
        if (tok_in_valid)
        begin
            unique case (tok_in.func)
                rhtt_pkg::OP_ADD:
                begin
                    if (!tok_in.claimed && !valid_reg)
                    begin
                        valid_next       = 1'b1;
                        flag_next        = 1'b0;
                        rect_next        = tok_in.rect;
                        tok_next.claimed = 1'b1;
                        tok_next.idx     = 4'(cell_id);
                    end
                end
                rhtt_pkg::OP_REMOVE:
                begin
                    if (slot_match)
                    begin
                        valid_next = 1'b0;
                        flag_next  = 1'b0;
                    end
                end
                rhtt_pkg::OP_EDIT:
                begin
                    if (slot_match && valid_reg)
                    begin
                        rect_next = tok_in.rect;
                    end
                end
                rhtt_pkg::OP_CLICK:
                begin
                    if (valid_reg)
                    begin
                        flag_next = hit;
                    end
                end
                rhtt_pkg::OP_QUERY:
                begin
                    if (slot_match && flag_reg)
                    begin
                        tok_next.got = 1'b1;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    // Control state of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            flag_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            flag_reg      <= flag_next;
            tok_valid_reg <= tok_in_valid;
        end
    end

    // Bounds and the request handed to the neighbor.
    always_ff @(posedge clk)
    begin
        rect_reg <= rect_next;
        if (tok_in_valid)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;
    assign flag          = flag_reg;

endmodule

`default_nettype wire

FILE: rtl/region_hit_test_table_top.sv
// An accepted request passes through the register of each cell in turn and then the output
// register before m_tvalid rises. One request is handled at a time: the request walks the cell
// chain and the next one enters once the result has moved into the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, asynchronous) empties every slot and clears all clicked flags.
`default_nettype none

module region_hit_test_table_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // func[2:0], slot[6:3], x_left[22:7], y_top[38:23], x_right[54:39],
    // y_bottom[70:55], point_x[86:71], point_y[102:87], zero[103]
    input  wire logic [rhtt_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // slot_index[3:0], table_full[4], slot_clicked[5], hit_mask[21:6], zero[23:22]
    output logic [rhtt_pkg::OUT_DATA_W-1:0]          m_tdata
);

    logic                  accept;
    rhtt_pkg::cmd_t        entry;
    logic                  chain_valid [rhtt_pkg::SLOTS];
    rhtt_pkg::cmd_t        chain_tok   [rhtt_pkg::SLOTS];
    logic [rhtt_pkg::SLOTS-1:0] flags;
    logic [15:0]           hit_mask;
    rhtt_pkg::cmd_t        last_tok;
    logic                  last_valid;
    rhtt_pkg::res_t        res;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    rhtt_pkg::res_t        out_reg;
    rhtt_pkg::res_t        out_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    rhtt_pkg::res_t        pend_reg;
    rhtt_pkg::res_t        pend_next;
    logic                  out_free;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    // Unpack the request; the answer fields start cleared.
    always_comb
    begin
        entry.func     = rhtt_pkg::op_t'(s_tdata[2:0]);
        entry.slot     = s_tdata[6:3];
        entry.rect     = s_tdata[70:7];
        entry.point_x  = s_tdata[86:71];
        entry.point_y  = s_tdata[102:87];
        entry.claimed  = 1'b0;
        entry.idx      = 4'd0;
        entry.got      = 1'b0;
    end

    // The chain of slot cells, each handing the request to the next.
    for (genvar g = 0; g < rhtt_pkg::SLOTS; g++)
    begin : g_cell
        logic           in_valid;
        rhtt_pkg::cmd_t in_tok;
        if (g == 0)
        begin : g_head
            assign in_valid = accept;
            assign in_tok   = entry;
        end
        else
        begin : g_link
            assign in_valid = chain_valid[g-1];
            assign in_tok   = chain_tok[g-1];
        end
        rhtt_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_id       (rhtt_pkg::IDX_W'(g)),
            .tok_in_valid  (in_valid),
            .tok_in        (in_tok),
            .tok_out_valid (chain_valid[g]),
            .tok_out       (chain_tok[g]),
            .flag          (flags[g])
        );
    end

    // Flags of the first sixteen slots form the mask.
    for (genvar m = 0; m < 16; m++)
    begin : g_mask
        if (m < rhtt_pkg::SLOTS)
        begin : g_used
            assign hit_mask[m] = flags[m];
        end
        else
        begin : g_unused
            assign hit_mask[m] = 1'b0;
        end
    end

    assign last_valid = chain_valid[rhtt_pkg::SLOTS-1];
    assign last_tok   = chain_tok[rhtt_pkg::SLOTS-1];

    // Result of the request leaving the chain.
    always_comb
    begin
        res.slot_index   = last_tok.idx;
        res.table_full   = (last_tok.func == rhtt_pkg::OP_ADD) && !last_tok.claimed;
        res.slot_clicked = last_tok.got;
        res.hit_mask     = hit_mask;
    end

    assign out_free = !out_valid_reg || m_tready;

    // Output register with a holding register behind it.
    always_comb
    begin
        busy_next       = busy_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        priority if (pend_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
                busy_next       = 1'b0;
            end
        end
        else if (last_valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_next       = res;
                busy_next      = 1'b0;
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_next       = res;
            end
        end
        else
        begin
            // Nothing leaves the chain in this cycle.
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(rhtt_pkg::OUT_DATA_W - rhtt_pkg::RES_W)'(0), out_reg};

endmodule

`default_nettype wire

FILE: rtl/rhtt_checker.sv
`default_nettype none

module rhtt_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [rhtt_pkg::IN_DATA_W-1:0]   s_tdata,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [rhtt_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // A waiting request stays offered with the same contents.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("request withdrawn or changed while waiting");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its contents.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: the chain is busy right after a request is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while the chain is busy");

    // A full table reports slot zero and never a clicked answer.
    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> (m_tdata[3:0] == 4'd0) && !m_tdata[5])
        else $error("full-table result carries stray fields");

endmodule

bind region_hit_test_table_top rhtt_checker u_rhtt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhtt_pkg::*;

    // Spare function codes that the block must treat as no-ops.
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    localparam int RANDOM_PER_PHASE = 450;
    localparam int RX_HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 40;

    // Tracks the region table and checks every result against the oldest expectation.
    class hit_table_scoreboard;
        rect_t region[SLOTS];
        bit    occupied[SLOTS];
        bit    clicked[SLOTS];
        res_t  expected_q[$];
        int    mismatches;

        function new();
            foreach (occupied[i])
            begin
                region[i]   = '0;
                occupied[i] = 1'b0;
                clicked[i]  = 1'b0;
            end
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit point_in(rect_t r, logic signed [15:0] px, logic signed [15:0] py);
            return (px >= r.x_left) && (px <= r.x_right) && (py >= r.y_top) && (py <= r.y_bottom);
        endfunction

        // Apply one accepted request to the table and queue the result it must produce.
        function void note_request(logic [IN_DATA_W-1:0] data);
            logic [2:0]         func;
            logic [3:0]         slot;
            rect_t              rect;
            logic signed [15:0] px;
            logic signed [15:0] py;
            res_t               res;
            func = data[2:0];
            slot = data[6:3];
            rect = data[70:7];
            px   = data[86:71];
            py   = data[102:87];
            res  = '0;
            case (func)
                OP_ADD:
                begin
                    res.table_full = 1'b1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!occupied[i])
                        begin
                            occupied[i]    = 1'b1;
                            clicked[i]     = 1'b0;
                            region[i]      = rect;
                            res.slot_index = i[3:0];
                            res.table_full = 1'b0;
                            break;
                        end
                    end
                end
                OP_REMOVE:
                begin
                    occupied[slot] = 1'b0;
                    clicked[slot]  = 1'b0;
                end
                OP_EDIT:
                begin
                    if (occupied[slot])
                        region[slot] = rect;
                end
                OP_CLICK:
                begin
                    // Empty slots keep whatever flag they had.
                    foreach (occupied[i])
                        if (occupied[i])
                            clicked[i] = point_in(region[i], px, py);
                end
                OP_QUERY:
                begin
                    res.slot_clicked = clicked[slot];
                end
                default:
                begin
                end
            endcase
            foreach (clicked[i])
                res.hit_mask[i] = clicked[i];
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compare one accepted result field by field.
        task check_result(logic [OUT_DATA_W-1:0] data);
            res_t got;
            res_t want;
            got = data[RES_W-1:0];
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no request outstanding", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.slot_index !== want.slot_index)
                report_mismatch($sformatf("slot_index %0d, expected %0d",
                                          got.slot_index, want.slot_index));
            if (got.table_full !== want.table_full)
                report_mismatch($sformatf("table_full %0b, expected %0b",
                                          got.table_full, want.table_full));
            if (got.slot_clicked !== want.slot_clicked)
                report_mismatch($sformatf("slot_clicked %0b, expected %0b",
                                          got.slot_clicked, want.slot_clicked));
            if (got.hit_mask !== want.hit_mask)
                report_mismatch($sformatf("hit_mask %h, expected %h",
                                          got.hit_mask, want.hit_mask));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    hit_table_scoreboard sb = new();

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int stall_cycles = 0;

    region_hit_test_table_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Observe both handshakes at the rising edge and count cycles with no progress.
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_request(s_tdata);
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Watchdog on lack of progress.
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("region_hit_test_table_top test failed");
        $finish;
    end

    // Result side: random back-pressure plus one long hold when asked.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = RX_HOLD_CYCLES - 1;
                m_tready  = 1'b0;
            end
            else
                m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_request(logic [2:0] func, logic [3:0] slot,
                                                          rect_t rect, logic signed [15:0] px,
                                                          logic signed [15:0] py);
        return {1'b0, py, px, rect, slot, func};
    endfunction

    function automatic rect_t make_rect(int xl, int yt, int xr, int yb);
        rect_t r;
        r.x_left   = xl[15:0];
        r.y_top    = yt[15:0];
        r.x_right  = xr[15:0];
        r.y_bottom = yb[15:0];
        return r;
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Mostly small coordinates so rectangles overlap, with extremes and full-range values.
    function automatic int random_coord();
        int pick;
        pick = $urandom_range(7);
        case (pick)
            0:
            begin
                case ($urandom_range(3))
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    default: return -1;
                endcase
            end
            1: return int'($urandom_range(65535)) - 32768;
            default: return int'($urandom_range(600)) - 300;
        endcase
    endfunction

    function automatic rect_t random_rect();
        int x0;
        int y0;
        int x1;
        int y1;
        int pick;
        x0 = random_coord();
        y0 = random_coord();
        x1 = clamp16(x0 + int'($urandom_range(400)));
        y1 = clamp16(y0 + int'($urandom_range(400)));
        pick = $urandom_range(7);
        // Occasionally an inverted or fully random rectangle.
        if (pick == 0)
            return make_rect(x1 + 1, y0, x0, y1);
        if (pick == 1)
            return make_rect(random_coord(), random_coord(), random_coord(), random_coord());
        return make_rect(x0, y0, x1, y1);
    endfunction

    // A coordinate on, just outside or inside the span lo..hi.
    function automatic int coord_near(int lo, int hi);
        case ($urandom_range(7))
            0: return lo;
            1: return hi;
            2: return clamp16(lo - 1);
            3: return clamp16(hi + 1);
            default:
            begin
                if (hi >= lo)
                    return lo + int'($urandom_range(hi - lo));
                return lo;
            end
        endcase
    endfunction

    // Random request shaped by the current table contents.
    function automatic logic [IN_DATA_W-1:0] random_request();
        int         live[$];
        int         pick;
        logic [2:0] func;
        logic [3:0] slot;
        rect_t      target;
        int         px;
        int         py;
        foreach (sb.occupied[i])
            if (sb.occupied[i])
                live.push_back(i);
        slot = 4'($urandom_range(15));
        if (live.size() > 0 && $urandom_range(9) < 7)
            slot = 4'(live[$urandom_range(live.size() - 1)]);
        px = random_coord();
        py = random_coord();
        if (live.size() > 0 && $urandom_range(1) == 1)
        begin
            target = sb.region[live[$urandom_range(live.size() - 1)]];
            px = coord_near(target.x_left, target.x_right);
            py = coord_near(target.y_top, target.y_bottom);
        end
        pick = $urandom_range(99);
        if (pick < 24)
            func = OP_ADD;
        else if (pick < 40)
            func = OP_REMOVE;
        else if (pick < 55)
            func = OP_EDIT;
        else if (pick < 85)
            func = OP_CLICK;
        else if (pick < 97)
            func = OP_QUERY;
        else
            func = 3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
        return pack_request(func, slot, random_rect(), px[15:0], py[15:0]);
    endfunction

    // Offer one request after a random gap and hold it until it is taken.
    task automatic send_request(logic [IN_DATA_W-1:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = data;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    initial
    begin
        rect_t r_full;
        r_full   = make_rect(-32768, -32768, 32767, 32767);
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty-slot operations, extreme rectangles, inclusive corners.
        tx_idle_pct = 38;
        rx_idle_pct = 50;
        send_request(pack_request(OP_REMOVE, 4'd15, '0, 16'sd0, 16'sd0));
        send_request(pack_request(OP_EDIT, 4'd3, r_full, 16'sd0, 16'sd0));
        send_request(pack_request(OP_ADD, 4'd0, r_full, 16'sd0, 16'sd0));
        send_request(pack_request(OP_ADD, 4'd0, make_rect(32767, 32767, 32767, 32767),
                                  16'sd0, 16'sd0));
        send_request(pack_request(OP_ADD, 4'd0, make_rect(100, 100, -100, -100),
                                  16'sd0, 16'sd0));
        send_request(pack_request(OP_ADD, 4'd0, make_rect(-32768, -32768, -32768, -32768),
                                  16'sd0, 16'sd0));
        send_request(pack_request(OP_CLICK, 4'd0, '0, 16'sh7fff, 16'sh7fff));
        send_request(pack_request(OP_CLICK, 4'd0, '0, 16'sh8000, 16'sh8000));
        send_request(pack_request(OP_QUERY, 4'd1, '0, 16'sd0, 16'sd0));
        send_request(pack_request(OP_EDIT, 4'd2, make_rect(-5, -5, 5, 5), 16'sd0, 16'sd0));
        send_request(pack_request(OP_CLICK, 4'd0, '0, 16'sd5, -16'sd5));
        send_request(pack_request(OP_QUERY, 4'd2, '0, 16'sd0, 16'sd0));
        send_request(pack_request(OP_REMOVE, 4'd0, '0, 16'sd0, 16'sd0));
        send_request(pack_request(OP_QUERY, 4'd0, '0, 16'sd0, 16'sd0));
        send_request(pack_request(FUNC_SPARE_FIRST, 4'd2, r_full, 16'sd0, 16'sd0));
        send_request(pack_request(FUNC_SPARE_LAST, 4'd2, r_full, 16'sd5, 16'sd5));
        // Fill every free slot, then add once more on the full table.
        repeat (13)
            send_request(pack_request(OP_ADD, 4'd0, random_rect(), 16'sd0, 16'sd0));
        send_request(pack_request(OP_ADD, 4'd0, r_full, 16'sd0, 16'sd0));

        // Random phases with shifting idle patterns; long result hold in the last.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 38;
                    rx_idle_pct = 50;
                end
                1:
                begin
                    tx_idle_pct = 50;
                    rx_idle_pct = 38;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_req    = 1'b1;
                end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_request(random_request());
        end
        s_tvalid = 1'b0;

        // Drain outstanding results, then watch for strays.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("region_hit_test_table_top test passed");
        else
            $display("region_hit_test_table_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
